### rtl/bracket_balance_checker_unit_macros.svh
// Assertion macros for the bracket checker.
// Each expects a clock named clk and an active-high reset named rst in scope.
`ifndef BRACKET_BALANCE_CHECKER_UNIT_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbc assertion failed");

// Next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbc assertion failed");

`else

`define BBC_ASSERT_IMP(lbl, ante, cons)
`define BBC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/bbc_pkg.sv
package bbc_pkg;

  // Default number of stack entries
  localparam int STACK_DEPTH_DEF = 64;

  // Character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN  = 8'h29;  // )
  localparam logic [7:0] CH_LSQUARE = 8'h5B;  // [
  localparam logic [7:0] CH_RSQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_LCURLY  = 8'h7B;  // {
  localparam logic [7:0] CH_RCURLY  = 8'h7D;  // }

  // Bracket kinds held on the stack
  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Verdict / error codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_WRONG     = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // Shift control for the stack: push and pop go to every cell, kind to the top cell
  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stk_ctrl_t;

  // Packed result word on the output stream
  typedef struct packed {
    logic [3:0] pad;
    status_t    status;
    logic       balanced;
  } result_t;

  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_LPAREN:  k = KIND_ROUND;
      CH_LSQUARE: k = KIND_SQUARE;
      CH_LCURLY:  k = KIND_CURLY;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_RPAREN:  k = KIND_ROUND;
      CH_RSQUARE: k = KIND_SQUARE;
      CH_RCURLY:  k = KIND_CURLY;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

### rtl/bbc_cell.sv
// One stack entry: takes from the cell above on push, from below on pop
module bbc_cell (
  input  logic           clk,
  input  logic           push,
  input  logic           pop,
  input  bbc_pkg::kind_t above,
  input  bbc_pkg::kind_t below,
  output bbc_pkg::kind_t kind
);
  import bbc_pkg::*;

  kind_t kind_next;

  always_comb begin
    if (push) begin
      kind_next = above;
    end else if (pop) begin
      kind_next = below;
    end else begin
      kind_next = kind;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    kind <= kind_next;
  end

endmodule

### rtl/bbc_stack.sv
// Shift-register stack: cell 0 is the top of stack
module bbc_stack #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  bbc_pkg::stk_ctrl_t ctrl,
  output bbc_pkg::kind_t     top_kind
);
  import bbc_pkg::*;

  kind_t kinds [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t above;
    kind_t below;

    // New kind enters at the top; the bottom cell refills from itself on pop
    if (i == 0) begin : g_top
      assign above = ctrl.kind;
    end else begin : g_mid
      assign above = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = kinds[i];
    end else begin : g_up
      assign below = kinds[i+1];
    end

    bbc_cell u_cell (
      .clk   (clk),
      .push  (ctrl.push),
      .pop   (ctrl.pop),
      .above (above),
      .below (below),
      .kind  (kinds[i])
    );
  end

  assign top_kind = kinds[0];

endmodule

### rtl/bbc_out_buf.sv
// Two-entry output buffer: main register plus skid register
module bbc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  bbc_pkg::result_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  output bbc_pkg::result_t out_data,
  input  logic             out_ready
);
  import bbc_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Main register refills from skid first, otherwise from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || out_ready) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          main_data  <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= in_valid;
          main_data  <= in_data;
        end
      end else if (in_valid) begin
        skid_valid <= 1'b1;
        skid_data  <= in_data;
      end
    end
  end

endmodule

### rtl/bracket_balance_checker_unit.sv
// Throughput: one character per cycle unless the buffer is full; one push or pop shifts the cell chain per transfer.
// Verdict reaches m_axis from the output buffer's main register, via the skid register if m_axis stalls.
// Input stays ready while a verdict waits, until the two-entry output buffer is full.
// Reset: clears depth, error code and output valids; stack cells are not cleared,
// as entries at or beyond the depth are never read. No clearing pass is needed.
module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] balanced, [3:1] status, [7:4] zero
);
  import bbc_pkg::*;

`include "bracket_balance_checker_unit_macros.svh"

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  logic      in_xfer;
  logic      buf_ready;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  status_t   err;
  status_t   err_next;
  status_t   verdict;
  kind_t     ok;
  kind_t     ck;
  kind_t     top_kind;
  stk_ctrl_t ctrl;
  logic      res_valid;
  result_t   res;
  result_t   out_word;

  assign s_axis_tready = buf_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign ok            = open_kind(s_axis_tdata);
  assign ck            = close_kind(s_axis_tdata);

  // Bracket handling for the character in transfer
  always_comb begin
    ctrl       = '{push: 1'b0, pop: 1'b0, kind: ok};
    depth_next = depth;
    err_next   = err;
    if (in_xfer && err == ST_OK) begin
      if (ok != KIND_NONE) begin
        if (depth == FULL) begin
          err_next = ST_OVERFLOW;
        end else begin
          ctrl.push  = 1'b1;
          depth_next = depth + DW'(1);
        end
      end else if (ck != KIND_NONE) begin
        if (depth == '0) begin
          err_next = ST_UNMATCHED;
        end else if (top_kind != ck) begin
          err_next = ST_WRONG;
        end else begin
          ctrl.pop   = 1'b1;
          depth_next = depth - DW'(1);
        end
      end
    end
  end

  // Verdict on the last character
  always_comb begin
    if (err_next != ST_OK) begin
      verdict = err_next;
    end else if (depth_next != '0) begin
      verdict = ST_UNCLOSED;
    end else begin
      verdict = ST_OK;
    end
    res_valid = in_xfer && s_axis_tlast;
    res       = '{pad: 4'd0, status: verdict, balanced: (verdict == ST_OK)};
  end

  // Depth and sticky error; both clear after the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      err   <= ST_OK;
    end else if (res_valid) begin
      depth <= '0;
      err   <= ST_OK;
    end else begin
      depth <= depth_next;
      err   <= err_next;
    end
  end

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .ctrl     (ctrl),
    .top_kind (top_kind)
  );

  bbc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (buf_ready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_word),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = out_word;

  // Checks
  `BBC_ASSERT_IMP(a_depth_range, 1'b1, depth <= FULL)
  `BBC_ASSERT_IMP(a_no_push_full, ctrl.push, depth != FULL)
  `BBC_ASSERT_NXT(a_clear_after_last, in_xfer && s_axis_tlast, depth == '0 && err == ST_OK)
  `BBC_ASSERT_NXT(a_err_freezes_depth, err != ST_OK && !res_valid, depth == $past(depth))

endmodule

### tb/bracket_balance_checker_unit_test.sv
module bracket_balance_checker_unit_test;
  import bbc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1350;

  // Running prediction of the checker and the queue of verdicts still owed
  class verdict_board;
    kind_t       kinds [STACK_DEPTH_DEF];
    int unsigned depth;
    int unsigned deepest;
    status_t     err;
    result_t     owed_q [$];
    int          mismatches;
    int          chars_seen;
    int          verdicts_seen;
    int          by_status [5];

    function new();
      depth = 0;
      deepest = 0;
      err = ST_OK;
      mismatches = 0;
      chars_seen = 0;
      verdicts_seen = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Input transfer: advance the stack and owe a verdict on the last character
    function void note_char(logic [7:0] c, logic last);
      logic    is_open;
      logic    is_close;
      kind_t   k;
      status_t verdict;
      result_t want;
      is_open = 1'b0;
      is_close = 1'b0;
      k = KIND_NONE;
      case (c)
        CH_LPAREN:  begin is_open = 1'b1;  k = KIND_ROUND;  end
        CH_LSQUARE: begin is_open = 1'b1;  k = KIND_SQUARE; end
        CH_LCURLY:  begin is_open = 1'b1;  k = KIND_CURLY;  end
        CH_RPAREN:  begin is_close = 1'b1; k = KIND_ROUND;  end
        CH_RSQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
        CH_RCURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
        default: ;
      endcase
      chars_seen++;
      // errors are sticky until the end of the string
      if (err == ST_OK) begin
        if (is_open) begin
          if (depth == STACK_DEPTH_DEF) begin
            err = ST_OVERFLOW;
          end else begin
            kinds[depth] = k;
            depth++;
            if (depth > deepest) deepest = depth;
          end
        end else if (is_close) begin
          if (depth == 0) err = ST_UNMATCHED;
          else if (kinds[depth-1] != k) err = ST_WRONG;
          else depth--;
        end
      end
      if (last) begin
        if (err != ST_OK) verdict = err;
        else if (depth != 0) verdict = ST_UNCLOSED;
        else verdict = ST_OK;
        want.pad = '0;
        want.status = verdict;
        want.balanced = (verdict == ST_OK);
        owed_q.push_back(want);
        by_status[verdict]++;
        depth = 0;
        err = ST_OK;
      end
    endfunction

    // Output transfer: compare with the oldest verdict owed
    function void check_verdict(logic [7:0] word);
      result_t got;
      result_t want;
      got = word;
      verdicts_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: verdict %h with none expected", word);
        return;
      end
      want = owed_q.pop_front();
      if (got.balanced !== want.balanced || got.status !== want.status ||
          got.pad !== want.pad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on verdict %0d: expected balanced=%0d status=%0d pad=%h, got balanced=%0d status=%0d pad=%h",
                   verdicts_seen, want.balanced, want.status, want.pad,
                   got.balanced, got.status, got.pad);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;

  verdict_board board = new();

  logic [7:0] text [$];
  bit         calm;
  int         hold_left;
  int         chars_sent;
  int         cycle_count;
  int         stall_cycles;

  bracket_balance_checker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // Monitor: verdicts are checked before the same edge's input is noted
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) board.note_char(s_axis_tdata, s_axis_tlast);
      if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, board.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] opener(kind_t k);
    case (k)
      KIND_ROUND:  return CH_LPAREN;
      KIND_SQUARE: return CH_LSQUARE;
      default:     return CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] closer(kind_t k);
    case (k)
      KIND_ROUND:  return CH_RPAREN;
      KIND_SQUARE: return CH_RSQUARE;
      default:     return CH_RCURLY;
    endcase
  endfunction

  function automatic kind_t any_kind();
    return kind_t'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] any_bracket();
    return $urandom_range(0, 1) ? opener(any_kind()) : closer(any_kind());
  endfunction

  // Well-formed nesting with stray bytes in between
  function automatic void build_nested(int max_depth, int steps);
    kind_t open_q [$];
    kind_t k;
    int    r;
    text.delete();
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 45 && open_q.size() < max_depth) begin
        k = any_kind();
        open_q.push_back(k);
        text.push_back(opener(k));
      end else if (r < 80 && open_q.size() > 0) begin
        text.push_back(closer(open_q.pop_back()));
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (open_q.size() > 0) text.push_back(closer(open_q.pop_back()));
    if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
  endfunction

  // A run of opens of random kinds followed by all their closes
  function automatic void build_deep(int opens);
    kind_t open_q [$];
    kind_t k;
    text.delete();
    repeat (opens) begin
      k = any_kind();
      open_q.push_back(k);
      text.push_back(opener(k));
    end
    while (open_q.size() > 0) text.push_back(closer(open_q.pop_back()));
  endfunction

  // Damage a well-formed string in one of several ways
  function automatic void break_text();
    int         closes [$];
    int         i;
    int         mode;
    logic [7:0] c;
    mode = $urandom_range(0, 3);
    foreach (text[j])
      if (text[j] == CH_RPAREN || text[j] == CH_RSQUARE || text[j] == CH_RCURLY)
        closes.push_back(j);
    if (mode == 0 && closes.size() == 0) mode = 1;
    case (mode)
      0: begin
        i = closes[$urandom_range(0, closes.size() - 1)];
        do c = closer(any_kind()); while (c == text[i]);
        text[i] = c;
      end
      1: text.insert($urandom_range(0, text.size()), opener(any_kind()));
      2: begin
        if ($urandom_range(0, 1)) text.push_front(closer(any_kind()));
        else text.insert($urandom_range(0, text.size()), closer(any_kind()));
      end
      default: begin
        if (text.size() > 1) void'(text.pop_back());
        else text.push_back(closer(any_kind()));
      end
    endcase
  endfunction

  // One transfer on the input side, with random gaps unless calm
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_string(input string s);
    text.delete();
    foreach (s[i]) text.push_back(s[i]);
    send_text();
  endtask

  initial begin
    int r;
    int d;
    bit pressured;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    calm = 1'b0;
    hold_left = 0;
    chars_sent = 0;
    cycle_count = 0;
    stall_cycles = 0;
    pressured = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, every bracket, unmatched, wrong and unclosed errors, sticky error
    text = '{8'h00};
    send_text();
    text = '{8'hFF};
    send_text();
    send_string("()");
    send_string("[]");
    send_string("{}");
    send_string(")");
    send_string("(]");
    send_string("{");
    send_string("}([");
    send_string("[})");
    send_string("({[]})");

    // Stack filled exactly, then one push too many
    build_deep(STACK_DEPTH_DEF);
    send_text();
    build_deep(STACK_DEPTH_DEF + 1);
    send_text();

    // Random strings: mostly well-formed, some damaged, some plain noise
    while (chars_sent < 24 + RANDOM_ITEMS) begin
      calm = (chars_sent >= 800 && chars_sent < 1100);
      if (!pressured && chars_sent > 500) begin
        // receiver holds off while short strings pile up behind it
        pressured = 1'b1;
        hold_left = 400;
        repeat (16) begin
          text.delete();
          repeat ($urandom_range(1, 3)) text.push_back(any_bracket());
          send_text();
        end
      end
      r = $urandom_range(0, 99);
      if (r < 87) begin
        if ($urandom_range(0, 49) == 0) build_nested(STACK_DEPTH_DEF + 2, $urandom_range(60, 160));
        else begin
          d = $urandom_range(1, 6);
          build_nested(d, $urandom_range(1, 20));
        end
        if (r >= 62) break_text();
      end else begin
        text.delete();
        repeat ($urandom_range(1, 12))
          text.push_back($urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
      end
      send_text();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain the verdicts still owed, then allow for the output latency
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d characters checked, %0d verdicts: %0d ok, %0d unmatched, %0d wrong kind, %0d unclosed, %0d overflow",
             board.chars_seen, board.verdicts_seen, board.by_status[ST_OK],
             board.by_status[ST_UNMATCHED], board.by_status[ST_WRONG],
             board.by_status[ST_UNCLOSED], board.by_status[ST_OVERFLOW]);
    $display("deepest nesting %0d, input held off for %0d cycles, %0d mismatches",
             board.deepest, stall_cycles, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
